// ===== rtl/core/gtg_pkg.sv =====
`default_nettype none
package gtg_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] linear_vel;
    logic signed [31:0] angular_vel;
    logic               arrived;
    logic        [30:0] distance_error;
  } out_word_t;

  typedef enum logic [2:0] {
    REG_GOAL_X        = 3'd0,
    REG_GOAL_Y        = 3'd1,
    REG_ARRIVE_TOL    = 3'd2,
    REG_LINEAR_GAIN   = 3'd3,
    REG_ANGULAR_GAIN  = 3'd4,
    REG_LINEAR_LIMIT  = 3'd5,
    REG_ANGULAR_LIMIT = 3'd6
  } cfg_reg_t;

  localparam logic signed [31:0] GOAL_X_RST        = 32'sd196608;
  localparam logic signed [31:0] GOAL_Y_RST        = 32'sd196608;
  localparam logic        [30:0] ARRIVE_TOL_RST    = 31'd32768;
  localparam logic        [30:0] LINEAR_GAIN_RST   = 31'd19661;
  localparam logic        [30:0] ANGULAR_GAIN_RST  = 31'd262144;
  localparam logic        [30:0] LINEAR_LIMIT_RST  = 31'd13107;
  localparam logic signed [31:0] ANGULAR_LIMIT_RST = 32'sd32768;

  // pi/2 in Q2.30
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

  function automatic logic [30:0] atan_q30(input logic [4:0] idx);
    logic [30:0] v;
    unique case (idx)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      5'd24: v = 31'd64;
      5'd25: v = 31'd32;
      5'd26: v = 31'd16;
      5'd27: v = 31'd8;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      5'd30: v = 31'd1;
      5'd31: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gtg_isqrt.sv =====
`default_nettype none
module gtg_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] v_in,
  output logic             done,
  output logic      [31:0] root
);
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= v_in;
        r    <= '0;
        bitv <= 64'd1 << 62;
        cnt  <= 5'd31;
        busy <= 1'b1;
      end else if (busy) begin
        if (v >= trial) begin
          v <= v - trial;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/gtg_cordic.sv =====
`default_nettype none
module gtg_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [32:0] y_in,
  input  wire logic signed [32:0] x_in,
  output logic                    done,
  output logic signed [33:0]      z
);
  import gtg_pkg::*;

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic signed [63:0] x, y;
  logic signed [63:0] xs, ys;
  logic signed [63:0] x0, y0;
  logic signed [33:0] tab;
  logic [CW-1:0]      cnt;
  logic [4:0]         idx;
  logic               busy;

  assign x0  = 64'(x_in) <<< 24;
  assign y0  = 64'(y_in) <<< 24;
  assign xs  = x >>> idx;
  assign ys  = y >>> idx;
  assign tab = $signed({3'b000, atan_q30(idx)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        idx <= '0;
        cnt <= CW'(CORDIC_STEPS - 1);
        if (x_in == '0 && y_in == '0) begin
          z    <= '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          if (x0 < 0) begin
            if (y0 >= 0) begin
              x <= y0;
              y <= -x0;
              z <= HALF_PI_Q30;
            end else begin
              x <= -y0;
              y <= x0;
              z <= -HALF_PI_Q30;
            end
          end else begin
            x <= x0;
            y <= y0;
            z <= '0;
          end
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + tab;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - tab;
        end
        idx <= idx + 5'd1;
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/go_to_goal_proportional_steer.sv =====
// An accepted word runs through two 32-step square-root passes and two CORDIC
// passes, run in turn, before its result word; once the goal is reached the
// angle passes are skipped.
// A new word is not taken while one is in work; in_stall is
// high from accept until the result is loaded into the output register.
// Reset (rst, synchronous): config registers to defaults, arrived latch cleared.
`default_nettype none
module go_to_goal_proportional_steer #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gtg_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output gtg_pkg::out_word_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import gtg_pkg::*;

  typedef enum logic [3:0] {
    IDLE, ABS, SQX, SQY, SUM, DIST, CHK, LIN, BEAR, ASQ, ASQW, YAW, ANG, ANG2, DONE
  } state_t;

  state_t state;

  logic signed [31:0] goal_x, goal_y, angular_limit;
  logic        [30:0] arrive_tolerance, linear_gain, angular_gain, linear_limit;
  logic               goal_reached;

  logic signed [32:0] dx, dy;
  logic signed [15:0] q;
  logic        [31:0] ax, ay;
  logic               big;
  logic        [63:0] sumsq;
  logic        [32:0] d;
  logic        [30:0] dout;
  logic        [30:0] lin;
  logic signed [33:0] bearing;
  logic signed [32:0] err;
  logic signed [31:0] ang;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic               sq_start, sq_done;
  logic        [63:0] sq_v;
  logic        [31:0] sq_root;
  logic               co_start, co_done;
  logic signed [32:0] co_y, co_x;
  logic signed [33:0] co_z;

  logic signed [32:0] adx, ady;
  logic               big_c;
  logic        [64:0] lin_full;
  logic        [48:0] lin_sh;
  logic signed [35:0] err_full;
  logic signed [65:0] ang_full;
  logic               in_acc, out_free;

  assign in_stall = (state != IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign adx   = dx[32] ? -dx : dx;
  assign ady   = dy[32] ? -dy : dy;
  assign big_c = adx[32] | adx[31] | ady[32] | ady[31];

  assign lin_full = 65'(prod[63:0]) + (d[32] ? {2'b00, linear_gain, 32'd0} : 65'd0);
  assign lin_sh   = lin_full[64:16];
  assign err_full = 36'(bearing) - (36'(co_z) <<< 1) + 36'sd8192;
  assign ang_full = prod >>> 16;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      SQX: begin
        mul_a = $signed({1'b0, ax});
        mul_b = $signed({1'b0, ax});
      end
      SQY: begin
        mul_a = $signed({1'b0, ay});
        mul_b = $signed({1'b0, ay});
      end
      CHK: begin
        mul_a = $signed({2'b00, linear_gain});
        mul_b = $signed({1'b0, d[31:0]});
      end
      BEAR: begin
        mul_a = 33'(q);
        mul_b = 33'(q);
      end
      ANG: begin
        mul_a = $signed({2'b00, angular_gain});
        mul_b = err;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    sq_start = 1'b0;
    sq_v     = sumsq + prod[63:0];
    co_start = 1'b0;
    co_y     = dy;
    co_x     = dx;
    unique case (state)
      SUM: sq_start = 1'b1;
      ASQ: begin
        sq_start = 1'b1;
        sq_v     = (64'd1 << 30) - prod[63:0];
      end
      LIN: co_start = 1'b1;
      ASQW: begin
        co_y     = 33'(q);
        co_x     = $signed({1'b0, sq_root});
        co_start = sq_done;
      end
      default: begin
        sq_start = 1'b0;
        co_start = 1'b0;
      end
    endcase
  end

  gtg_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .v_in  (sq_v),
    .done  (sq_done),
    .root  (sq_root)
  );

  gtg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (co_start),
    .y_in  (co_y),
    .x_in  (co_x),
    .done  (co_done),
    .z     (co_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x           <= GOAL_X_RST;
      goal_y           <= GOAL_Y_RST;
      arrive_tolerance <= ARRIVE_TOL_RST;
      linear_gain      <= LINEAR_GAIN_RST;
      angular_gain     <= ANGULAR_GAIN_RST;
      linear_limit     <= LINEAR_LIMIT_RST;
      angular_limit    <= ANGULAR_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GOAL_X:        goal_x           <= cfg_data;
        REG_GOAL_Y:        goal_y           <= cfg_data;
        REG_ARRIVE_TOL:    arrive_tolerance <= cfg_data[30:0];
        REG_LINEAR_GAIN:   linear_gain      <= cfg_data[30:0];
        REG_ANGULAR_GAIN:  angular_gain     <= cfg_data[30:0];
        REG_LINEAR_LIMIT:  linear_limit     <= cfg_data[30:0];
        REG_ANGULAR_LIMIT: angular_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      goal_reached <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            dx    <= 33'(goal_x) - 33'(in_data.pos_x);
            dy    <= 33'(goal_y) - 33'(in_data.pos_y);
            q     <= in_data.quat_z;
            state <= ABS;
          end
        end
        ABS: begin
          big   <= big_c;
          ax    <= big_c ? adx[32:1] : adx[31:0];
          ay    <= big_c ? ady[32:1] : ady[31:0];
          state <= SQX;
        end
        SQX: state <= SQY;
        SQY: begin
          sumsq <= prod[63:0];
          state <= SUM;
        end
        SUM: state <= DIST;
        DIST: begin
          if (sq_done) begin
            d     <= big ? {sq_root, 1'b0} : {1'b0, sq_root};
            state <= CHK;
          end
        end
        CHK: begin
          dout <= (d > 33'h07FFFFFFF) ? 31'h7FFFFFFF : d[30:0];
          if (goal_reached || d <= 33'(arrive_tolerance)) begin
            goal_reached <= 1'b1;
            lin          <= '0;
            ang          <= '0;
            state        <= DONE;
          end else begin
            state <= LIN;
          end
        end
        LIN: begin
          lin   <= (lin_sh > 49'(linear_limit)) ? linear_limit : lin_sh[30:0];
          state <= BEAR;
        end
        BEAR: begin
          if (co_done) begin
            bearing <= co_z;
            state   <= ASQ;
          end
        end
        ASQ:  state <= ASQW;
        ASQW: begin
          if (sq_done) begin
            state <= YAW;
          end
        end
        YAW: begin
          if (co_done) begin
            err   <= 33'(err_full >>> 14);
            state <= ANG;
          end
        end
        ANG: state <= ANG2;
        ANG2: begin
          if (ang_full > 66'(angular_limit)) begin
            ang <= angular_limit;
          end else if (ang_full < -66'sd2147483648) begin
            ang <= 32'sh80000000;
          end else begin
            ang <= ang_full[31:0];
          end
          state <= DONE;
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == DONE && out_free) begin
      out_data.linear_vel     <= $signed({1'b0, lin});
      out_data.angular_vel    <= ang;
      out_data.arrived        <= goal_reached;
      out_data.distance_error <= dout;
    end
  end

  a_latch_holds: assert property (@(posedge clk) disable iff (rst)
    goal_reached |=> goal_reached)
    else $error("arrived latch dropped");

  a_arrived_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.arrived |->
      out_data.linear_vel == 32'sd0 && out_data.angular_vel == 32'sd0)
    else $error("drive not zero after arrival");

  a_lin_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.linear_vel <= $signed({1'b0, linear_limit}))
    else $error("linear drive above limit");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("accepted word did not start work");

endmodule
`default_nettype wire
